### sv/tps_pkg.sv
// ----------------------------------------------------------------------------
// Trapezoidal pulse shaper package
// Shared widths, register indexes and sizes for the shaper and its output
// queue.
// ----------------------------------------------------------------------------
package tps_pkg;

  localparam int DELAY_DEPTH = 8192;
  localparam int SAMPLE_BITS = 16;

  localparam int ADDR_BITS    = $clog2(DELAY_DEPTH);
  localparam int CFG_BITS     = 12;
  localparam int TAP_BITS     = CFG_BITS + 1;
  localparam int SEEN_BITS    = 14;
  localparam int ACC_BITS     = 32;
  localparam int DELTA_BITS   = SAMPLE_BITS + 2;
  localparam int S_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

  localparam logic [SEEN_BITS-1:0] SEEN_MAX = {SEEN_BITS{1'b1}};

  localparam logic [CFG_BITS-1:0] RISE_LENGTH_RESET = 12'd2500;
  localparam logic [CFG_BITS-1:0] GAP_DELAY_RESET   = 12'd3000;

  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RISE_LENGTH = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAP_DELAY   = 1'b1;

  localparam int OUT_FIFO_DEPTH = 4;
  localparam int OUT_PTR_BITS   = $clog2(OUT_FIFO_DEPTH);
  localparam int OUT_LEVEL_BITS = $clog2(OUT_FIFO_DEPTH + 1);

endpackage

### sv/trapezoidal_pulse_shaper_top.sv
// ----------------------------------------------------------------------------
// Trapezoidal pulse shaper
// Shapes a stream of baseline-corrected detector samples into a trapezoid
// by the recursion y[n] = y[n-1] + x[n] - x[n-k] - x[n-l] + x[n-l-k].
//
// Usage: samples enter on the s_ group, one per transaction, with the
// waveform start mark in s_tuser. Each sample gives exactly one shaped value
// on the m_ group. Rise length k and gap delay l are written through the cfg
// group while the stream is idle. Taps that reach before the waveform start
// read as zero.
// Throughput is one sample per cycle while s_tready is high: each sample
// needs one write and three reads of the delay line, held in two memories
// written alike, one for two of the reads, one for the third. A shaped
// value passes the tap and difference registers and the output queue.
// When the receiver stalls, results collect in a four-entry output queue and
// s_tready drops once the queue and the pipeline together would fill it.
// Reset clears the pointers, the sample count, the accumulator and the
// queue and reloads k = 2500 and l = 3000. The delay memories are not
// cleared; the sample count keeps every read on entries already written.
// ----------------------------------------------------------------------------
module trapezoidal_pulse_shaper_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [tps_pkg::S_TDATA_BITS-1:0] s_tdata,   // sample_in
  input  logic                             s_tuser,   // first_sample
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [tps_pkg::ACC_BITS-1:0]     m_tdata,   // shaped_out
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [tps_pkg::CFG_BITS-1:0]     cfg_data
);

  logic [tps_pkg::SAMPLE_BITS-1:0] mem_a [tps_pkg::DELAY_DEPTH];
  logic [tps_pkg::SAMPLE_BITS-1:0] mem_b [tps_pkg::DELAY_DEPTH];

  logic [tps_pkg::CFG_BITS-1:0]  rise_length;
  logic [tps_pkg::CFG_BITS-1:0]  gap_delay;
  logic [tps_pkg::ADDR_BITS-1:0] write_pointer;
  logic [tps_pkg::SEEN_BITS-1:0] samples_seen;
  logic [tps_pkg::ACC_BITS-1:0]  trapezoid_acc;

  logic                          accept;
  logic [tps_pkg::SAMPLE_BITS-1:0] sample_in;
  logic [tps_pkg::SEEN_BITS-1:0] seen_eff;
  logic [tps_pkg::SEEN_BITS-1:0] samples_seen_next;
  logic [tps_pkg::TAP_BITS-1:0]  d_k;
  logic [tps_pkg::TAP_BITS-1:0]  d_l;
  logic [tps_pkg::TAP_BITS-1:0]  d_lk;
  logic [tps_pkg::ADDR_BITS-1:0] addr_k;
  logic [tps_pkg::ADDR_BITS-1:0] addr_l;
  logic [tps_pkg::ADDR_BITS-1:0] addr_lk;

  // Stage 1: memory read data and tap qualifiers.
  logic                            v1;
  logic                            first1;
  logic signed [tps_pkg::SAMPLE_BITS-1:0] x1;
  logic signed [tps_pkg::SAMPLE_BITS-1:0] rd_k;
  logic signed [tps_pkg::SAMPLE_BITS-1:0] rd_l;
  logic signed [tps_pkg::SAMPLE_BITS-1:0] rd_lk;
  logic [2:0]                      tap_vld1;
  logic [2:0]                      tap_cur1;
  logic signed [tps_pkg::SAMPLE_BITS-1:0] t_k;
  logic signed [tps_pkg::SAMPLE_BITS-1:0] t_l;
  logic signed [tps_pkg::SAMPLE_BITS-1:0] t_lk;
  logic signed [tps_pkg::DELTA_BITS-1:0]  delta_next;

  // Stage 2: sample difference ready for the accumulator.
  logic                            v2;
  logic                            first2;
  logic signed [tps_pkg::DELTA_BITS-1:0]  delta2;
  logic [tps_pkg::ACC_BITS-1:0]    trapezoid_acc_next;

  logic [tps_pkg::OUT_LEVEL_BITS-1:0] fifo_level;
  logic [tps_pkg::OUT_LEVEL_BITS:0]   committed;

  assign cfg_ready = 1'b1;
  assign sample_in = s_tdata[tps_pkg::SAMPLE_BITS-1:0];

  assign committed = {1'b0, fifo_level} + (tps_pkg::OUT_LEVEL_BITS + 1)'(v1)
                   + (tps_pkg::OUT_LEVEL_BITS + 1)'(v2);
  assign s_tready  = (committed < (tps_pkg::OUT_LEVEL_BITS + 1)'(tps_pkg::OUT_FIFO_DEPTH));
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rise_length <= tps_pkg::RISE_LENGTH_RESET;
      gap_delay   <= tps_pkg::GAP_DELAY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tps_pkg::REG_RISE_LENGTH: rise_length <= cfg_data;
        tps_pkg::REG_GAP_DELAY:   gap_delay   <= cfg_data;
        default:                  rise_length <= rise_length;
      endcase
    end
  end

  always_comb begin
    seen_eff = s_tuser ? '0 : samples_seen;
    if (seen_eff < tps_pkg::SEEN_MAX) begin
      samples_seen_next = seen_eff + 1'b1;
    end else begin
      samples_seen_next = seen_eff;
    end
    d_k     = {1'b0, rise_length};
    d_l     = {1'b0, gap_delay};
    d_lk    = d_k + d_l;
    addr_k  = write_pointer - tps_pkg::ADDR_BITS'(d_k);
    addr_l  = write_pointer - tps_pkg::ADDR_BITS'(d_l);
    addr_lk = write_pointer - tps_pkg::ADDR_BITS'(d_lk);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      samples_seen  <= '0;
    end else if (accept) begin
      write_pointer <= write_pointer + 1'b1;
      samples_seen  <= samples_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mem_a[write_pointer] <= sample_in;
      mem_b[write_pointer] <= sample_in;
      rd_k  <= mem_a[addr_k];
      rd_l  <= mem_a[addr_l];
      rd_lk <= mem_b[addr_lk];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x1          <= sample_in;
      first1      <= s_tuser;
      tap_vld1[0] <= (tps_pkg::SEEN_BITS'(d_k) <= seen_eff) && (32'(d_k) < tps_pkg::DELAY_DEPTH);
      tap_vld1[1] <= (tps_pkg::SEEN_BITS'(d_l) <= seen_eff) && (32'(d_l) < tps_pkg::DELAY_DEPTH);
      tap_vld1[2] <= (tps_pkg::SEEN_BITS'(d_lk) <= seen_eff)
                     && (32'(d_lk) < tps_pkg::DELAY_DEPTH);
      tap_cur1[0] <= (d_k == '0);
      tap_cur1[1] <= (d_l == '0);
      tap_cur1[2] <= (d_lk == '0);
    end
  end

  // A tap at offset zero is the sample being written in the same cycle.
  always_comb begin
    t_k  = !tap_vld1[0] ? '0 : (tap_cur1[0] ? x1 : rd_k);
    t_l  = !tap_vld1[1] ? '0 : (tap_cur1[1] ? x1 : rd_l);
    t_lk = !tap_vld1[2] ? '0 : (tap_cur1[2] ? x1 : rd_lk);
    delta_next = tps_pkg::DELTA_BITS'(x1) - tps_pkg::DELTA_BITS'(t_k)
               - tps_pkg::DELTA_BITS'(t_l) + tps_pkg::DELTA_BITS'(t_lk);
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      delta2 <= delta_next;
      first2 <= first1;
    end
  end

  assign trapezoid_acc_next = (first2 ? '0 : trapezoid_acc) + tps_pkg::ACC_BITS'(delta2);

  always_ff @(posedge clk) begin
    if (rst) begin
      trapezoid_acc <= '0;
    end else if (v2) begin
      trapezoid_acc <= trapezoid_acc_next;
    end
  end

  tps_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (v2),
    .push_data (trapezoid_acc_next),
    .level     (fifo_level),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

### sv/tps_out_fifo.sv
// ----------------------------------------------------------------------------
// Shaper output queue
// Small register queue that holds shaped values until the receiver takes
// them and reports its fill level for flow control.
// ----------------------------------------------------------------------------
module tps_out_fifo (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  input  logic [tps_pkg::ACC_BITS-1:0]       push_data,
  output logic [tps_pkg::OUT_LEVEL_BITS-1:0] level,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [tps_pkg::ACC_BITS-1:0]       m_tdata     // shaped_out
);

  logic [tps_pkg::ACC_BITS-1:0]       entries [tps_pkg::OUT_FIFO_DEPTH];
  logic [tps_pkg::OUT_PTR_BITS-1:0]   wr_ptr;
  logic [tps_pkg::OUT_PTR_BITS-1:0]   rd_ptr;
  logic [tps_pkg::OUT_LEVEL_BITS-1:0] count;
  logic                               pop;

  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (count != '0);
  assign m_tdata  = entries[rd_ptr];
  assign level    = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule
